FILE: rtl/tlag_pkg.sv
// Shared types and constants of the tiled layout address generator.
`default_nettype none

package tlag_pkg;

  // Geometry of the tiled layout (bytes and rows)
  localparam int MICRO_BYTES_WIDE   = 16;
  localparam int MICRO_ROWS         = 4;
  localparam int SUBTILE_ROWS       = 16;
  localparam int SUBTILE_BYTES_WIDE = 64;
  localparam int TILE_ROWS          = 2 * SUBTILE_ROWS;
  localparam int TILE_BYTES_WIDE    = 2 * SUBTILE_BYTES_WIDE;

  // Default limit on tiles across, and the fixed limit on tiles down
  localparam int MAX_TILES_ACROSS_DEF = 256;
  localparam int TILES_HIGH_LIMIT     = 256;

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int STRIDE_W = 16;
  localparam int COUNT_W  = 9;
  localparam int ROW_W    = 8;
  localparam int IDX_W    = 3;
  localparam int LROWS_W  = ROW_W + 5;    // linear row within the image
  localparam int LBYTES_W = COUNT_W + 7;  // byte offset within a linear row

  // Register indexes
  localparam logic [IDX_W-1:0] REG_ROW_STRIDE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_TILES_WIDE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_TILES_HIGH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SOURCE_BASE = 3'd3;
  localparam logic [IDX_W-1:0] REG_DEST_BASE   = 3'd4;

  // Register reset values
  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = 16'd512;
  localparam logic [COUNT_W-1:0]  TILES_RST      = 9'd1;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [STRIDE_W-1:0] row_stride;
    logic [COUNT_W-1:0]  tiles_wide;
    logic [COUNT_W-1:0]  tiles_high;
    logic [ADDR_W-1:0]   source_base;
    logic [ADDR_W-1:0]   dest_base;
  } cfg_t;

  // Position of one output line, handed from the walker to the address stage
  typedef struct packed {
    logic [COUNT_W-1:0] col;         // reflected, clamped tile column
    logic [ROW_W-1:0]   row;         // clamped tile row
    logic [1:0]         place;       // bit 0 lower half, bit 1 right half
    logic [3:0]         micro;       // micro-tile in raster order
    logic [1:0]         line;        // line inside the micro-tile
    logic [ADDR_W-1:0]  line_count;  // output lines since image start
    logic               last;        // final line of the image
  } pos_t;

endpackage

`default_nettype wire

FILE: rtl/tlag_walk.sv
// Serpentine tile walker: position counters and the position register.
`default_nettype none

module tlag_walk #(
  parameter int MAX_TILES_ACROSS = tlag_pkg::MAX_TILES_ACROSS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tlag_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  input  wire logic          in_restart,
  output logic               in_stall,
  input  wire logic          take,
  output logic               pos_valid,
  output tlag_pkg::pos_t     pos
);
  import tlag_pkg::*;

  // Column counter covers the largest usable tile count
  localparam int COL_LIMIT = (MAX_TILES_ACROSS < 511) ? MAX_TILES_ACROSS : 511;
  localparam int COL_W     = (COL_LIMIT > 1) ? $clog2(COL_LIMIT) : 1;

  logic [COL_W-1:0]   tile_column_r, tile_column_nxt;
  logic [ROW_W-1:0]   tile_row_r, tile_row_nxt;
  logic [1:0]         subtile_step_r, subtile_step_nxt;
  logic [3:0]         microtile_step_r, microtile_step_nxt;
  logic [1:0]         line_r, line_nxt;
  logic [ADDR_W-1:0]  line_count_r, line_count_nxt;
  logic               pos_valid_r;
  pos_t               pos_r, pos_nxt;

  logic               accept;
  logic [COUNT_W-1:0] w_eff, h_eff, w_m1, h_m1;
  logic [COL_W-1:0]   col_st;
  logic [ROW_W-1:0]   row_st;
  logic [1:0]         sub_st, line_st;
  logic [3:0]         micro_st;
  logic [ADDR_W-1:0]  lc_st;
  logic [COUNT_W-1:0] col_x, row_x, col_c, row_c;
  logic               odd, last_col, last_row, last_in_tile, last;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = pos_valid_r && !take;
  assign pos_valid = pos_valid_r;
  assign pos       = pos_r;

  // Effective tile counts: zero acts as one, oversized counts are clamped
  always_comb begin
    if (cfg.tiles_wide == '0) begin
      w_eff = COUNT_W'(1);
    end else if (32'(cfg.tiles_wide) > MAX_TILES_ACROSS) begin
      w_eff = COUNT_W'(COL_LIMIT);
    end else begin
      w_eff = cfg.tiles_wide;
    end
    if (cfg.tiles_high == '0) begin
      h_eff = COUNT_W'(1);
    end else if (32'(cfg.tiles_high) > TILES_HIGH_LIMIT) begin
      h_eff = COUNT_W'(TILES_HIGH_LIMIT);
    end else begin
      h_eff = cfg.tiles_high;
    end
    w_m1 = w_eff - COUNT_W'(1);
    h_m1 = h_eff - COUNT_W'(1);
  end

  // Counters as seen by this word: restart starts from the first line
  always_comb begin
    col_st   = in_restart ? '0 : tile_column_r;
    row_st   = in_restart ? '0 : tile_row_r;
    sub_st   = in_restart ? '0 : subtile_step_r;
    micro_st = in_restart ? '0 : microtile_step_r;
    line_st  = in_restart ? '0 : line_r;
    lc_st    = in_restart ? '0 : line_count_r;
  end

  // Clamp, reflect odd rows, pick the sub-tile and detect the end
  always_comb begin
    col_x = COUNT_W'(col_st);
    row_x = COUNT_W'(row_st);
    col_c = (col_x < w_m1) ? col_x : w_m1;
    row_c = (row_x < h_m1) ? row_x : h_m1;
    odd   = row_c[0];

    pos_nxt.col = odd ? (w_m1 - col_c) : col_c;
    pos_nxt.row = row_c[ROW_W-1:0];
    case (sub_st)
      2'd0:    pos_nxt.place = odd ? 2'd3 : 2'd0;
      2'd1:    pos_nxt.place = odd ? 2'd2 : 2'd1;
      2'd2:    pos_nxt.place = odd ? 2'd0 : 2'd3;
      default: pos_nxt.place = odd ? 2'd1 : 2'd2;
    endcase
    pos_nxt.micro      = micro_st;
    pos_nxt.line       = line_st;
    pos_nxt.line_count = lc_st;

    last_in_tile = (sub_st == 2'd3) && (micro_st == 4'd15) && (line_st == 2'd3);
    last_col     = col_x >= w_m1;
    last_row     = row_x >= h_m1;
    last         = last_in_tile && last_col && last_row;
    pos_nxt.last = last;
  end

  // Advance the walk: line, micro-tile, sub-tile, tile column, tile row
  always_comb begin
    tile_column_nxt    = col_st;
    tile_row_nxt       = row_st;
    subtile_step_nxt   = sub_st;
    microtile_step_nxt = micro_st;
    line_nxt           = line_st;
    line_count_nxt     = lc_st + ADDR_W'(1);
    if (last) begin
      tile_column_nxt    = '0;
      tile_row_nxt       = '0;
      subtile_step_nxt   = '0;
      microtile_step_nxt = '0;
      line_nxt           = '0;
      line_count_nxt     = '0;
    end else if (line_st != 2'd3) begin
      line_nxt = line_st + 2'd1;
    end else begin
      line_nxt = '0;
      if (micro_st != 4'd15) begin
        microtile_step_nxt = micro_st + 4'd1;
      end else begin
        microtile_step_nxt = '0;
        if (sub_st != 2'd3) begin
          subtile_step_nxt = sub_st + 2'd1;
        end else begin
          subtile_step_nxt = '0;
          if (!last_col) begin
            tile_column_nxt = col_st + COL_W'(1);
          end else begin
            tile_column_nxt = '0;
            tile_row_nxt    = last_row ? '0 : row_st + ROW_W'(1);
          end
        end
      end
    end
  end

  // Counter and position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_column_r    <= '0;
      tile_row_r       <= '0;
      subtile_step_r   <= '0;
      microtile_step_r <= '0;
      line_r           <= '0;
      line_count_r     <= '0;
      pos_valid_r      <= 1'b0;
    end else begin
      if (accept) begin
        tile_column_r    <= tile_column_nxt;
        tile_row_r       <= tile_row_nxt;
        subtile_step_r   <= subtile_step_nxt;
        microtile_step_r <= microtile_step_nxt;
        line_r           <= line_nxt;
        line_count_r     <= line_count_nxt;
      end
      if (!pos_valid_r || take) begin
        pos_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  // Checks on the walk
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (line_count_r == '0 && tile_column_r == '0 && tile_row_r == '0))
    else $error("counters not cleared after last line");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_restart && !last) |=> (line_count_r == $past(line_count_r) + ADDR_W'(1)))
    else $error("line count did not advance by one");

  a_last_at_tile_end: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_valid_r && pos_r.last) |-> (pos_r.line == 2'd3 && pos_r.micro == 4'd15))
    else $error("last line flagged inside a micro-tile");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tile_column_r) < COL_LIMIT)
    else $error("tile column beyond limit");

endmodule

`default_nettype wire

FILE: rtl/tlag_addr.sv
// Address stage: source and destination addresses and the result register.
`default_nettype none

module tlag_addr (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tlag_pkg::cfg_t          cfg,
  input  wire logic                    pos_valid,
  input  wire tlag_pkg::pos_t          pos,
  output logic                         take,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [tlag_pkg::ADDR_W-1:0]  out_source_address,
  output logic [tlag_pkg::ADDR_W-1:0]  out_dest_address,
  output logic                         out_last_line
);
  import tlag_pkg::*;

  logic [LROWS_W-1:0]          rows;
  logic [LBYTES_W-1:0]         bytes;
  logic [LROWS_W+STRIDE_W-1:0] row_offset;
  logic [ADDR_W-1:0]           src_nxt, dst_nxt;
  logic [ADDR_W-1:0]           src_r, dst_r;
  logic                        last_r, valid_r;

  assign take = !valid_r || !out_stall;

  // Linear row and byte offset: the low fields pack tile geometry directly
  // (32 rows and 128 bytes a tile, 16/4 rows and 64/16 bytes below that)
  always_comb begin
    rows       = {pos.row, pos.place[0], pos.micro[3:2], pos.line};
    bytes      = {pos.col, pos.place[1], pos.micro[1:0], 4'd0};
    row_offset = rows * cfg.row_stride;
    src_nxt    = cfg.source_base + ADDR_W'(row_offset) + ADDR_W'(bytes);
    dst_nxt    = cfg.dest_base + {pos.line_count[ADDR_W-5:0], 4'd0};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pos_valid) begin
      src_r  <= src_nxt;
      dst_r  <= dst_nxt;
      last_r <= pos.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_source_address = src_r;
  assign out_dest_address   = dst_r;
  assign out_last_line      = last_r;

endmodule

`default_nettype wire

FILE: rtl/tiled_layout_address_generator.sv
// Top level of the tiled layout address generator.
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_stall   in_restart
//   out      output     out_valid / out_stall out_source_address, out_dest_address,
//                                             out_last_line
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One word per cycle sustained while out_stall stays low; a request passes the
// walker position register, then the address register holding the one
// stride multiply and the base add.
// Reset (rst_n low, synchronous) returns the walk to the first line and loads
// the register defaults. out_stall holds the result register; in_stall rises
// in the same cycle only once both the position and result registers are full.
`default_nettype none

module tiled_layout_address_generator #(
  parameter int MAX_TILES_ACROSS = tlag_pkg::MAX_TILES_ACROSS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [tlag_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [tlag_pkg::ADDR_W-1:0] cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_restart,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [tlag_pkg::ADDR_W-1:0]  out_source_address,
  output logic [tlag_pkg::ADDR_W-1:0]  out_dest_address,
  output logic                         out_last_line
);
  import tlag_pkg::*;

  cfg_t cfg_r;
  pos_t pos;
  logic pos_valid;
  logic take;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_stride  <= ROW_STRIDE_RST;
      cfg_r.tiles_wide  <= TILES_RST;
      cfg_r.tiles_high  <= TILES_RST;
      cfg_r.source_base <= '0;
      cfg_r.dest_base   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_STRIDE:  cfg_r.row_stride  <= cfg_data[STRIDE_W-1:0];
        REG_TILES_WIDE:  cfg_r.tiles_wide  <= cfg_data[COUNT_W-1:0];
        REG_TILES_HIGH:  cfg_r.tiles_high  <= cfg_data[COUNT_W-1:0];
        REG_SOURCE_BASE: cfg_r.source_base <= cfg_data;
        REG_DEST_BASE:   cfg_r.dest_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  tlag_walk #(
    .MAX_TILES_ACROSS(MAX_TILES_ACROSS)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_restart(in_restart),
    .in_stall  (in_stall),
    .take      (take),
    .pos_valid (pos_valid),
    .pos       (pos)
  );

  tlag_addr u_addr (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .pos_valid         (pos_valid),
    .pos               (pos),
    .take              (take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_source_address(out_source_address),
    .out_dest_address  (out_dest_address),
    .out_last_line     (out_last_line)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tlag_checker.sv
// Line address checker: models the tiled walk and compares every result word.
module tlag_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tlag_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tlag_pkg::ADDR_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_restart,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [tlag_pkg::ADDR_W-1:0] out_source_address,
  input  logic [tlag_pkg::ADDR_W-1:0] out_dest_address,
  input  logic                        out_last_line,
  output int                          lines_pending,
  output int                          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlag_pkg::*;

  // Sub-tile quadrants: bit 0 lower half, bit 1 right half
  typedef enum logic [1:0] {
    TOP_LEFT     = 2'b00,
    BOTTOM_LEFT  = 2'b01,
    TOP_RIGHT    = 2'b10,
    BOTTOM_RIGHT = 2'b11
  } quadrant_t;

  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
    logic              last_line;
  } line_addr_t;

  // Register copies
  logic [STRIDE_W-1:0] stride_r;
  logic [COUNT_W-1:0]  wide_r;
  logic [COUNT_W-1:0]  high_r;
  logic [ADDR_W-1:0]   src_base_r;
  logic [ADDR_W-1:0]   dst_base_r;

  // Walk position
  logic [ROW_W-1:0]  across_pos;  // position along the serpentine row
  logic [ROW_W-1:0]  down_pos;
  logic [1:0]        quad_step;
  logic [3:0]        micro_step;
  logic [1:0]        line_step;
  logic [ADDR_W-1:0] lines_out;

  line_addr_t lines_due[$];

  function automatic int tile_limit(input logic [COUNT_W-1:0] v, input int cap);
    if (v == '0) return 1;
    return (int'(v) > cap) ? cap : int'(v);
  endfunction

  // Even tile rows go down the left half first, odd rows start bottom right
  function automatic quadrant_t quadrant_at(input logic [1:0] step, input logic odd_row);
    if (!odd_row) begin
      case (step)
        2'd0:    return TOP_LEFT;
        2'd1:    return BOTTOM_LEFT;
        2'd2:    return BOTTOM_RIGHT;
        default: return TOP_RIGHT;
      endcase
    end
    case (step)
      2'd0:    return BOTTOM_RIGHT;
      2'd1:    return TOP_RIGHT;
      2'd2:    return TOP_LEFT;
      default: return BOTTOM_LEFT;
    endcase
  endfunction

  function automatic void rewind_walk();
    across_pos = '0;
    down_pos   = '0;
    quad_step  = '0;
    micro_step = '0;
    line_step  = '0;
    lines_out  = '0;
  endfunction

  // Addresses of the next tiled line, then advance the walk
  function automatic line_addr_t walk_line(input logic restart);
    int                w, h, col, row;
    logic              odd_row, end_col, end_row, end_image, lower, right;
    quadrant_t         quad;
    logic [ADDR_W-1:0] lin_row, lin_byte;
    line_addr_t        res;
    w = tile_limit(wide_r, MAX_TILES_ACROSS_DEF);
    h = tile_limit(high_r, TILES_HIGH_LIMIT);
    if (restart) rewind_walk();

    // counts may have shrunk under the walk: clamp to the last tile
    col = (int'(across_pos) < w - 1) ? int'(across_pos) : w - 1;
    row = (int'(down_pos) < h - 1) ? int'(down_pos) : h - 1;
    odd_row = row[0];
    if (odd_row) col = w - 1 - col;
    quad  = quadrant_at(quad_step, odd_row);
    lower = (quad == BOTTOM_LEFT) || (quad == BOTTOM_RIGHT);
    right = (quad == TOP_RIGHT) || (quad == BOTTOM_RIGHT);

    lin_row  = row * TILE_ROWS + (lower ? SUBTILE_ROWS : 0)
             + micro_step[3:2] * MICRO_ROWS + line_step;
    lin_byte = col * TILE_BYTES_WIDE + (right ? SUBTILE_BYTES_WIDE : 0)
             + micro_step[1:0] * MICRO_BYTES_WIDE;

    end_col   = int'(across_pos) >= w - 1;
    end_row   = int'(down_pos) >= h - 1;
    end_image = (&quad_step) && (&micro_step) && (&line_step) && end_col && end_row;

    res.source_address = src_base_r + lin_row * stride_r + lin_byte;
    res.dest_address   = dst_base_r + lines_out * MICRO_BYTES_WIDE;
    res.last_line      = end_image;

    // counters carry line -> micro-tile -> sub-tile -> tile
    if (end_image) begin
      rewind_walk();
    end else begin
      lines_out++;
      line_step++;
      if (line_step == '0) begin
        micro_step++;
        if (micro_step == '0) begin
          quad_step++;
          if (quad_step == '0) begin
            if (end_col) begin
              across_pos = '0;
              down_pos   = end_row ? '0 : down_pos + 1'b1;
            end else begin
              across_pos++;
            end
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void flag(input string what, input logic [ADDR_W-1:0] want_v,
                               input logic [ADDR_W-1:0] got_v);
    if (mismatches < 10)
      $display("[%0t] %s: expected %h, got %h", $time, what, want_v, got_v);
    mismatches++;
  endfunction

  // Register writes, result compare, then prediction of accepted words
  always @(posedge clk) begin
    line_addr_t want;
    if (!rst_n) begin
      stride_r   = ROW_STRIDE_RST;
      wide_r     = TILES_RST;
      high_r     = TILES_RST;
      src_base_r = '0;
      dst_base_r = '0;
      rewind_walk();
      lines_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_STRIDE:  stride_r   = cfg_data[STRIDE_W-1:0];
          REG_TILES_WIDE:  wide_r     = cfg_data[COUNT_W-1:0];
          REG_TILES_HIGH:  high_r     = cfg_data[COUNT_W-1:0];
          REG_SOURCE_BASE: src_base_r = cfg_data;
          REG_DEST_BASE:   dst_base_r = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (lines_due.size() == 0) begin
          flag("line with none expected", '0, out_source_address);
        end else begin
          want = lines_due.pop_front();
          if (out_source_address !== want.source_address)
            flag("source_address", want.source_address, out_source_address);
          if (out_dest_address !== want.dest_address)
            flag("dest_address", want.dest_address, out_dest_address);
          if (out_last_line !== want.last_line)
            flag("last_line", {31'd0, want.last_line}, {31'd0, out_last_line});
        end
      end
      if (in_valid && !in_stall) lines_due.push_back(walk_line(in_restart));
    end
    lines_pending = lines_due.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the address generator testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tlag_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 160;
  localparam int DRAIN_CYCLES    = 4;  // two-stage pipe plus margin

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [ADDR_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              in_restart;
  logic              out_valid;
  logic              out_stall;
  logic [ADDR_W-1:0] out_source_address;
  logic [ADDR_W-1:0] out_dest_address;
  logic              out_last_line;

  int lines_pending;
  int mismatches;
  int send_idle_pct = 11;
  int recv_idle_pct = 62;
  int holds_asked   = 0;
  int holds_served  = 0;
  int words_sent    = 0;
  int quiet_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tiled_layout_address_generator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_source_address (out_source_address),
    .out_dest_address   (out_dest_address),
    .out_last_line      (out_last_line)
  );

  tlag_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_source_address (out_source_address),
    .out_dest_address   (out_dest_address),
    .out_last_line      (out_last_line),
    .lines_pending      (lines_pending),
    .mismatches         (mismatches)
  );

  // Offer one request word, with a random gap first; returns at a falling edge
  task automatic send_line(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic run_lines(input int count, input int restart_one_in, input bit restart_first);
    logic restart;
    for (int k = 0; k < count; k++) begin
      // idling: sender light/receiver heavy, then swapped, then none
      if (words_sent < 460) begin
        send_idle_pct = 11;
        recv_idle_pct = 62;
      end else if (words_sent < 920) begin
        send_idle_pct = 62;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      restart = (k == 0 && restart_first) ||
                (restart_one_in > 0 && $urandom_range(restart_one_in - 1) == 0);
      send_line(restart);
      words_sent++;
    end
  endtask

  // Wait until every predicted line has come back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (lines_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Unused upper data bits carry noise; unmapped indexes get random writes
  task automatic set_geometry(input logic [STRIDE_W-1:0] stride,
                              input logic [COUNT_W-1:0] wide, input logic [COUNT_W-1:0] high,
                              input logic [ADDR_W-1:0] src_base,
                              input logic [ADDR_W-1:0] dst_base);
    write_reg(REG_ROW_STRIDE, {16'($urandom()), stride});
    write_reg(REG_TILES_WIDE, {23'($urandom()), wide});
    write_reg(REG_TILES_HIGH, {23'($urandom()), high});
    write_reg(REG_SOURCE_BASE, src_base);
    write_reg(REG_DEST_BASE, dst_base);
    for (int k = REG_DEST_BASE + 1; k < 2 ** IDX_W; k++) write_reg(IDX_W'(k), $urandom());
    cfg_we <= 1'b0;
  endtask

  // Result side: random stall, or a long hold-off when one is asked for
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served != holds_asked) begin
        hold_left = HOLD_OFF_CYCLES;
        holds_served++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any word moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_restart <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_ROW_STRIDE;
    cfg_data   <= '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // register defaults; restart first, back to back and on the last word
    for (int k = 0; k < 20; k++) send_line(k == 0 || k == 7 || k == 8 || k == 19);
    drain();

    // zero tile counts, zero stride, bases near the top: image end and wrap
    set_geometry(16'd0, 9'd0, 9'd0, 32'hFFFF_FFFF, 32'hFFFF_FF80);
    run_lines(270, 0, 1'b1);
    drain();

    // oversized tile counts, widest stride, frequent restarts;
    // the receiver holds off while words keep coming
    set_geometry(16'hFFFF, 9'h1FF, 9'(257 + $urandom_range(254)), $urandom(), 32'h0);
    holds_asked++;
    run_lines(80, 8, 1'b1);
    drain();

    // 2 x 3 tiles, walked into the second tile of the odd tile row
    set_geometry(16'($urandom_range(16, 65535)), 9'd2, 9'd3, $urandom(), $urandom());
    run_lines(400, 0, 1'b1);
    drain();
    run_lines(400, 0, 1'b0);
    drain();

    // shrink to one tile while the walk sits past both new limits
    set_geometry(16'd16, 9'd1, 9'd1, $urandom(), $urandom());
    run_lines(240, 0, 1'b0);
    drain();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tlag_pkg.sv
rtl/tlag_walk.sv
rtl/tlag_addr.sv
rtl/tiled_layout_address_generator.sv
tb/sv/tlag_checker.sv
tb/sv/tb_top.sv
